/* src/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// Learning switch forwarder package
// Field widths and stream packing shared by the forwarder and its checker.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int unsigned PortIdW   = 3;   // arrival_port
    localparam int unsigned AddrW     = 16;  // source / destination address
    localparam int unsigned MaskW     = 8;   // active_ports, send_ports
    localparam int unsigned EntryW    = AddrW + PortIdW;

    // slave tdata: arrival_port, source_address, destination_address
    localparam int unsigned InDataW   = 40;
    // master tdata: send_ports, flooded, learned, table_full
    localparam int unsigned OutDataW  = 16;
    localparam int unsigned OutUsedW  = MaskW + 3;

    localparam int unsigned OutFloodBit = MaskW;
    localparam int unsigned OutLearnBit = MaskW + 1;
    localparam int unsigned OutFullBit  = MaskW + 2;

endpackage

/* src/learning_switch_forwarder.sv */
// A request is taken in S_IDLE; the learned entries are then read one entry per
// cycle in S_SCAN and compared as the registered data returns, the last in S_DRAIN
// (an empty table or an inactive port goes straight to S_DONE). S_DONE registers the
// result once the output register is free; only then is the next request taken.
// Reset (synchronous, active low) clears the fill count, the FSM and the output
// valid and sets active_ports to all ones; the table RAM is not cleared.
// ----------------------------------------------------------------------------
// Learning switch forwarder
// Learns source addresses into a fill-ordered table and forwards on a
// destination lookup, flooding on a miss.
// ----------------------------------------------------------------------------
module learning_switch_forwarder #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned PORT_COUNT  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // packet header stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] arrival_port, [18:3] source_address, [34:19] destination_address
    input  logic [lsf_pkg::InDataW-1:0]   s_axis_tdata,
    // forwarding result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] send_ports, [8] flooded, [9] learned, [10] table_full
    output logic [lsf_pkg::OutDataW-1:0]  m_axis_tdata,
    // active_ports write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsf_pkg::MaskW-1:0]     i_cfg_data
);

    import lsf_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [MaskW-1:0] PortMask = MaskW'((1 << PORT_COUNT) - 1);
    localparam logic [CW-1:0]    FullCount = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_idx;
    logic               r_pend;
    logic [CW-1:0]      r_fill;
    logic [MaskW-1:0]   r_active;
    logic [PortIdW-1:0] r_port;
    logic [AddrW-1:0]   r_src;
    logic [AddrW-1:0]   r_dst;
    logic               r_drop;
    logic               r_src_found;
    logic               r_dst_found;
    logic [PortIdW-1:0] r_dst_port;
    logic               r_out_valid;
    logic [OutDataW-1:0] r_out_data;

    logic [MaskW-1:0]   active;
    logic [PortIdW-1:0] in_port;
    logic               in_accept;
    logic               rd_en;
    logic [EntryW-1:0]  rd_data;
    logic [AddrW-1:0]   rd_addr_val;
    logic [PortIdW-1:0] rd_port_val;
    logic               out_free;
    logic               n_learn;
    logic               n_full;
    logic               n_hit;
    logic [PortIdW-1:0] n_hit_port;
    logic [MaskW-1:0]   n_send;
    logic [OutDataW-1:0] n_out_data;
    logic               wr_en;
    logic [CW-1:0]      n_idx;

    assign active    = r_active & PortMask;
    assign in_port   = s_axis_tdata[PortIdW-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign rd_en       = (r_state == S_SCAN);
    assign rd_addr_val = rd_data[AddrW-1:0];
    assign rd_port_val = rd_data[EntryW-1:AddrW];
    assign n_idx       = r_idx + CW'(1);

    assign out_free = !r_out_valid || m_axis_tready;

    // learn into the next free slot; a same-address destination hits it at once
    always_comb begin
        n_learn    = !r_drop && !r_src_found && (r_fill != FullCount);
        n_full     = !r_drop && !r_src_found && (r_fill == FullCount);
        n_hit      = r_dst_found || (n_learn && (r_dst == r_src));
        n_hit_port = r_dst_found ? r_dst_port : r_port;
        if (n_hit) begin
            n_send = (MaskW'(1) << n_hit_port) & active;
        end else begin
            n_send = active & ~(MaskW'(1) << r_port);
        end
        n_out_data = '0;
        if (!r_drop) begin
            n_out_data[MaskW-1:0]   = n_send;
            n_out_data[OutFloodBit] = !n_hit;
            n_out_data[OutLearnBit] = n_learn;
            n_out_data[OutFullBit]  = n_full;
        end
    end

    assign wr_en = (r_state == S_DONE) && out_free && n_learn;

    lsf_ram #(
        .WIDTH (EntryW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data ({r_port, r_src}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_active    <= '1;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            // compare the entry read in the previous cycle
            if ((r_state == S_SCAN || r_state == S_DRAIN) && r_pend) begin
                if (rd_addr_val == r_src) begin
                    r_src_found <= 1'b1;
                end
                if (rd_addr_val == r_dst) begin
                    r_dst_found <= 1'b1;
                    r_dst_port  <= rd_port_val;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_port      <= in_port;
                        r_src       <= s_axis_tdata[PortIdW +: AddrW];
                        r_dst       <= s_axis_tdata[PortIdW + AddrW +: AddrW];
                        r_drop      <= !active[in_port];
                        r_src_found <= 1'b0;
                        r_dst_found <= 1'b0;
                        r_idx       <= '0;
                        r_pend      <= 1'b0;
                        if (!active[in_port] || r_fill == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx  <= n_idx;
                    r_pend <= 1'b1;
                    if (n_idx == r_fill) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= n_out_data;
                        if (n_learn) begin
                            r_fill <= r_fill + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* src/lsf_ram.sv */
// ----------------------------------------------------------------------------
// Forwarder table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsf_ram #(
    parameter int unsigned WIDTH  = 19,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/lsf_checker.sv */
// ----------------------------------------------------------------------------
// Learning switch forwarder checker
// Port-level assertions on the forwarder, attached by bind.
// ----------------------------------------------------------------------------
module lsf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lsf_pkg::OutDataW-1:0]  m_axis_tdata
);

    import lsf_pkg::*;

    // results come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one request in flight: no new header taken right after one is accepted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("header taken while another is in progress");

    // a new entry and a full table exclude each other
    a_learn_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[OutLearnBit] && m_axis_tdata[OutFullBit]))
        else $error("learned and table_full both set");

    // padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:OutUsedW] == '0))
        else $error("non-zero padding in result");

endmodule

bind learning_switch_forwarder lsf_checker u_lsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Learning switch forwarder testbench
// Streams packet headers into the forwarder under random idling on both sides.
// It walks a short directed plan first, then runs random phases under several
// port masks. Each forwarding result is checked against the expectation of its
// plan row or against a behavioural model of the learning table.
// ----------------------------------------------------------------------------
module testbench;
    import lsf_pkg::*;

    localparam int unsigned TableDepth    = 16;
    localparam int unsigned RandomItems   = 1925;
    localparam int unsigned HoldCycles    = 300;
    localparam int unsigned SettleCycles  = 25;
    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned MaxReports    = 10;

    typedef struct packed {
        logic [MaskW-1:0] send_ports;
        logic             flooded;
        logic             learned;
        logic             table_full;
    } fwd_result_t;

    typedef struct packed {
        logic [MaskW-1:0]   cfg;
        logic [PortIdW-1:0] port;
        logic [AddrW-1:0]   src;
        logic [AddrW-1:0]   dst;
        logic               typed;
        fwd_result_t        want;
    } header_row_t;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MaskW-1:0]    i_cfg_data;

    // model of the forwarding table, filled in order
    logic [AddrW-1:0]   learned_addr [TableDepth];
    logic [PortIdW-1:0] learned_port [TableDepth];
    int                 learned_count = 0;
    logic [MaskW-1:0]   active_mask = 8'hFF;

    fwd_result_t expected_forwards [$];
    int          failures = 0;
    int          send_burst = 0;
    int          recv_burst = 0;
    bit          hold_off_req = 1'b0;

    // Rows with typed = 1 carry an expectation read straight off the spec;
    // the rest are checked against the model.
    header_row_t header_plan [0:24] = '{
        // reset mask: learn, hit on own entry, flood skips the arrival port
        '{8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'h01, 1'b0, 1'b1, 1'b0}},
        '{8'hFF, 3'd7, 16'hFFFF, 16'h1234, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b0}},
        // known source on a new port stays where it was
        '{8'hFF, 3'd3, 16'hFFFF, 16'h0000, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b0}},
        '{8'hFF, 3'd5, 16'h1234, 16'hFFFF, 1'b1, '{8'h80, 1'b0, 1'b1, 1'b0}},
        // fill the rest of the table
        '{8'hFF, 3'd1, 16'h0001, 16'h1234, 1'b0, '0},
        '{8'hFF, 3'd2, 16'h0002, 16'h0001, 1'b0, '0},
        '{8'hFF, 3'd3, 16'h0004, 16'h5555, 1'b0, '0},
        '{8'hFF, 3'd4, 16'h0008, 16'h0004, 1'b0, '0},
        '{8'hFF, 3'd5, 16'h0010, 16'hAAAA, 1'b0, '0},
        '{8'hFF, 3'd6, 16'h0020, 16'h0010, 1'b0, '0},
        '{8'hFF, 3'd7, 16'h0040, 16'h0040, 1'b0, '0},
        '{8'hFF, 3'd0, 16'h0080, 16'h8000, 1'b0, '0},
        '{8'hFF, 3'd1, 16'h0100, 16'h0080, 1'b0, '0},
        '{8'hFF, 3'd2, 16'h0200, 16'h00FF, 1'b0, '0},
        '{8'hFF, 3'd3, 16'h0400, 16'h0200, 1'b0, '0},
        '{8'hFF, 3'd4, 16'h0800, 16'h7FFF, 1'b0, '0},
        '{8'hFF, 3'd6, 16'h1000, 16'h0800, 1'b0, '0},
        // table full: skip learning, still forward
        '{8'hFF, 3'd2, 16'h8000, 16'h0000, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b1}},
        '{8'hFF, 3'd4, 16'h8000, 16'h8000, 1'b1, '{8'hEF, 1'b1, 1'b0, 1'b1}},
        // partial mask: drop on inactive ports, hit onto an inactive port
        '{8'hA5, 3'd1, 16'h0002, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'hA5, 3'd6, 16'h4321, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'hA5, 3'd0, 16'h0000, 16'h0004, 1'b0, '0},
        '{8'hA5, 3'd0, 16'h0000, 16'h9999, 1'b1, '{8'hA4, 1'b1, 1'b0, 1'b0}},
        '{8'hA5, 3'd7, 16'h0040, 16'h0010, 1'b0, '0},
        // no link anywhere: everything dropped
        '{8'h00, 3'd0, 16'h0000, 16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}}
    };

    learning_switch_forwarder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Learn the source, then look up the destination, as the block does.
    function automatic fwd_result_t forward_header(input logic [PortIdW-1:0] port,
                                                   input logic [AddrW-1:0] src,
                                                   input logic [AddrW-1:0] dst);
        fwd_result_t      r;
        bit               src_known;
        int               hit;
        int               i;
        logic [MaskW-1:0] port_bit;
        r = '0;
        src_known = 1'b0;
        hit = -1;
        if (!active_mask[port]) begin
            return r;
        end
        for (i = 0; i < learned_count; i++) begin
            if (learned_addr[i] == src) begin
                src_known = 1'b1;
            end
        end
        if (!src_known) begin
            if (learned_count < TableDepth) begin
                learned_addr[learned_count] = src;
                learned_port[learned_count] = port;
                learned_count++;
                r.learned = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end
        for (i = 0; i < learned_count; i++) begin
            if (hit < 0 && learned_addr[i] == dst) begin
                hit = i;
            end
        end
        port_bit = '0;
        if (hit >= 0) begin
            port_bit[learned_port[hit]] = 1'b1;
            r.send_ports = port_bit & active_mask;
        end else begin
            port_bit[port] = 1'b1;
            r.send_ports = active_mask & ~port_bit;
            r.flooded = 1'b1;
        end
        return r;
    endfunction

    // Idle cycles before the next request, with runs of back-to-back ones.
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [AddrW-1:0] pick_address(input bit prefer_known);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (learned_count > 0 && roll < (prefer_known ? 60 : 45)) begin
            return learned_addr[$urandom_range(0, learned_count - 1)];
        end
        if (roll < 80) begin
            return 16'h8000 + AddrW'($urandom_range(0, 7));
        end
        return AddrW'($urandom_range(0, 65535));
    endfunction

    task automatic send_header(input logic [PortIdW-1:0] port,
                               input logic [AddrW-1:0] src,
                               input logic [AddrW-1:0] dst,
                               input logic typed,
                               input fwd_result_t want);
        logic [InDataW-1:0] word;
        fwd_result_t        predicted;
        int                 gap;
        word = '0;
        word[PortIdW-1:0] = port;
        word[PortIdW +: AddrW] = src;
        word[PortIdW + AddrW +: AddrW] = dst;
        gap = draw_gap(send_burst);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = forward_header(port, src, dst);
        expected_forwards.push_back(typed ? want : predicted);
    endtask

    // Drop valid and let every outstanding request come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_forwards.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_active_ports(input logic [MaskW-1:0] mask);
        i_cfg_data  <= mask;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_mask = mask;
    endtask

    initial begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HoldCycles;
            end else begin
                gap = draw_gap(recv_burst);
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_check
        fwd_result_t got;
        fwd_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.send_ports = m_axis_tdata[MaskW-1:0];
            got.flooded    = m_axis_tdata[OutFloodBit];
            got.learned    = m_axis_tdata[OutLearnBit];
            got.table_full = m_axis_tdata[OutFullBit];
            if (expected_forwards.size() == 0) begin
                failures++;
                if (failures <= MaxReports) begin
                    $display("unexpected result: send_ports %h flooded %b learned %b full %b",
                             got.send_ports, got.flooded, got.learned, got.table_full);
                end
            end else begin
                want = expected_forwards.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= MaxReports) begin
                        $display("mismatch: send_ports exp %h got %h, flooded exp %b got %b",
                                 want.send_ports, got.send_ports, want.flooded, got.flooded);
                        $display("          learned exp %b got %b, table_full exp %b got %b",
                                 want.learned, got.learned, want.table_full, got.table_full);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int                 i;
        int                 k;
        int                 n;
        int                 phase;
        int                 sent;
        logic [MaskW-1:0]   mask;
        logic [PortIdW-1:0] port;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(header_plan); i++) begin
            if (header_plan[i].cfg != active_mask) begin
                settle();
                write_active_ports(header_plan[i].cfg);
            end
            send_header(header_plan[i].port, header_plan[i].src, header_plan[i].dst,
                        header_plan[i].typed, header_plan[i].want);
        end

        sent = 0;
        phase = 0;
        while (sent < RandomItems) begin
            case (phase)
                0: mask = 8'hFF;
                1: mask = 8'h00;
                2: mask = 8'h01;
                3: mask = 8'h80;
                default: mask = MaskW'($urandom_range(0, 255));
            endcase
            n = (mask == '0) ? $urandom_range(10, 30) : $urandom_range(100, 250);
            settle();
            write_active_ports(mask);
            for (k = 0; k < n && sent < RandomItems; k++) begin
                // stall the sink for a long stretch so the input backs up
                if (phase == 0 && k == 60) begin
                    hold_off_req = 1'b1;
                end
                if (mask != '0 && $urandom_range(0, 4) != 0) begin
                    do port = PortIdW'($urandom_range(0, 7)); while (!mask[port]);
                end else begin
                    port = PortIdW'($urandom_range(0, 7));
                end
                send_header(port, pick_address(1'b1), pick_address(1'b0), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        settle();
        if (failures == 0 && expected_forwards.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
